// ----- src/ctrt_pkg.sv -----
// Package: shared types and constants of the station table tracker.
package ctrt_pkg;
    localparam int DEF_ENTRIES = 16;
    localparam int MAX_REMOVES = 16;
    localparam int MAC_W = 48;
    localparam int DBM_W = 8;
    localparam int AGE_W = 16;
    localparam int CNT_W = 32;
    localparam logic [15:0] MAX_AGE_RESET = 16'd10;

    localparam logic [1:0] EV_ADD    = 2'd0;
    localparam logic [1:0] EV_UPDATE = 2'd1;
    localparam logic [1:0] EV_REMOVE = 2'd2;
    localparam logic [1:0] EV_FULL   = 2'd3;

    localparam logic FUNC_OBSERVE = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    // One classified command from the front to the back.
    typedef struct packed {
        logic                    func;
        logic [MAC_W-1:0]        mac;
        logic signed [DBM_W-1:0] dbm;
    } cmd_t;

    // One result beat.
    typedef struct packed {
        logic [1:0]              kind;
        logic [MAC_W-1:0]        mac;
        logic signed [DBM_W-1:0] avg;
        logic signed [DBM_W-1:0] ref_dbm;
        logic [CNT_W-1:0]        added;
        logic [CNT_W-1:0]        removed;
        logic                    fin;
    } res_t;
endpackage

// ----- src/ctrt_front.sv -----
// Front: accept input beats, drop null and broadcast observes, queue commands.
module ctrt_front
    import ctrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  cmd_t       in_cmd,
    output logic       q_valid,
    input  logic       q_ready,
    output cmd_t       q_cmd
);
    // Two-entry queue.
    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       keep, push, pop;

    assign keep = (in_cmd.func == FUNC_TICK) ||
                  ((in_cmd.mac != '0) && (in_cmd.mac != {MAC_W{1'b1}}));
    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready && keep;
    assign pop = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- src/ctrt_back.sv -----
// Back: station table, parallel match on observe, sweep over entries on tick.
module ctrt_back
    import ctrt_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] max_age,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_cmd,
    output logic        out_valid,
    input  logic        out_ready,
    output res_t        out_res
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = $clog2(MAX_REMOVES + 1);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    logic [ENTRIES-1:0]        valid_reg;
    logic [MAC_W-1:0]          mac_reg  [ENTRIES];
    logic signed [DBM_W-1:0]   last_reg [ENTRIES];
    logic signed [DBM_W-1:0]   avg_reg  [ENTRIES];
    logic [AGE_W-1:0]          age_reg  [ENTRIES];
    logic [CNT_W-1:0]          add_reg, rem_reg;
    logic [1:0]                st_reg;
    logic [IW-1:0]             idx_reg;
    logic [RW-1:0]             nrem_reg;
    logic                      pend_reg;
    res_t                      pend_res_reg;
    res_t                      res_reg;
    logic                      ov_reg;

    // Parallel match and lowest free entry.
    logic [ENTRIES-1:0] hit;
    logic               any_hit, any_free;
    logic [IW-1:0]      hit_idx, free_idx;
    always_comb
    begin
        any_hit = 1'b0;
        any_free = 1'b0;
        hit_idx = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            hit[i] = valid_reg[i] && (mac_reg[i] == q_cmd.mac);
            if (hit[i])
            begin
                any_hit = 1'b1;
                hit_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // Average update for a hit.
    logic signed [DBM_W-1:0] h_avg, h_last, nav;
    logic signed [10:0]      sum;
    assign h_avg = avg_reg[hit_idx];
    assign h_last = last_reg[hit_idx];
    assign sum = 11'(h_avg) - 11'(h_last / 8) + 11'(q_cmd.dbm / 8);
    always_comb
    begin
        priority if (sum > 11'sd127) nav = 8'sd127;
        else if (sum < -11'sd128) nav = -8'sd128;
        else nav = sum[7:0];
    end
    logic signed [9:0] dlt;
    assign dlt = 10'(nav) - 10'(h_avg);
    logic moved;
    assign moved = (dlt > 10'sd1) || (dlt < -10'sd1);

    // Sweep entry.
    logic [AGE_W-1:0] s_age;
    logic             s_evict, last_idx;
    assign s_age = (age_reg[idx_reg] != {AGE_W{1'b1}}) ? age_reg[idx_reg] + 1'b1
                                                          : age_reg[idx_reg];
    assign s_evict = valid_reg[idx_reg] && (s_age > max_age) &&
                     (nrem_reg < RW'(MAX_REMOVES));
    assign last_idx = (idx_reg == IW'(ENTRIES - 1));

    logic out_free;
    assign out_free = !ov_reg || out_ready;
    assign q_ready = (st_reg == ST_IDLE) && out_free;
    assign out_valid = ov_reg;
    assign out_res = res_reg;

    // Step decisions: observe taken, sweep advance, and which beat loads the output.
    logic obs_go, obs_res, sw_adv, sw_emit, out_emit, ov_set;
    assign obs_go = (st_reg == ST_IDLE) && q_valid && out_free &&
                    (q_cmd.func == FUNC_OBSERVE);
    assign obs_res = obs_go && (!any_hit || moved);
    assign sw_adv = (st_reg == ST_SWEEP) && (!(s_evict && pend_reg) || out_free);
    assign sw_emit = sw_adv && s_evict && pend_reg;
    assign out_emit = (st_reg == ST_OUT) && pend_reg && out_free;
    assign ov_set = obs_res || sw_emit || out_emit;

    always_ff @(posedge clk)
    begin
        if (obs_go)
        begin
            if (any_hit)
            begin
                age_reg[hit_idx] <= '0;
                last_reg[hit_idx] <= q_cmd.dbm;
                avg_reg[hit_idx] <= nav;
            end
            else if (any_free)
            begin
                mac_reg[free_idx] <= q_cmd.mac;
                last_reg[free_idx] <= q_cmd.dbm;
                avg_reg[free_idx] <= q_cmd.dbm;
                age_reg[free_idx] <= '0;
            end
        end
        if (sw_adv && valid_reg[idx_reg])
        begin
            age_reg[idx_reg] <= s_age;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            add_reg <= '0;
            rem_reg <= '0;
            st_reg <= ST_IDLE;
            idx_reg <= '0;
            nrem_reg <= '0;
            pend_reg <= 1'b0;
            ov_reg <= 1'b0;
            res_reg <= '0;
            pend_res_reg <= '0;
        end
        else
        begin
            ov_reg <= ov_set || (ov_reg && !out_ready);
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (q_valid && out_free)
                    begin
                        if (q_cmd.func == FUNC_TICK)
                        begin
                            st_reg <= ST_SWEEP;
                            idx_reg <= '0;
                            nrem_reg <= '0;
                            pend_reg <= 1'b0;
                        end
                        else if (any_hit)
                        begin
                            if (moved)
                            begin
                                res_reg <= '{EV_UPDATE, q_cmd.mac, nav, h_avg,
                                             add_reg, rem_reg, 1'b1};
                            end
                        end
                        else if (any_free)
                        begin
                            valid_reg[free_idx] <= 1'b1;
                            add_reg <= add_reg + 1'b1;
                            res_reg <= '{EV_ADD, q_cmd.mac, q_cmd.dbm, q_cmd.dbm,
                                         add_reg + 1'b1, rem_reg, 1'b1};
                        end
                        else
                        begin
                            res_reg <= '{EV_FULL, q_cmd.mac, q_cmd.dbm, q_cmd.dbm,
                                         add_reg, rem_reg, 1'b1};
                        end
                    end
                end
                ST_SWEEP:
                begin
                    // Hold the latest removal until the next one is found or the
                    // sweep ends, so the last one can be flagged final.
                    if (sw_adv)
                    begin
                        if (sw_emit)
                            res_reg <= pend_res_reg;
                        if (s_evict)
                        begin
                            valid_reg[idx_reg] <= 1'b0;
                            rem_reg <= rem_reg + 1'b1;
                            nrem_reg <= nrem_reg + 1'b1;
                            pend_res_reg <= '{EV_REMOVE, mac_reg[idx_reg],
                                              avg_reg[idx_reg], last_reg[idx_reg],
                                              add_reg, rem_reg + 1'b1, 1'b0};
                            pend_reg <= 1'b1;
                        end
                        if (last_idx)
                            st_reg <= ST_OUT;
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (!pend_reg)
                        st_reg <= ST_IDLE;
                    else if (out_free)
                    begin
                        res_reg <= {pend_res_reg[$bits(res_t)-1:1], 1'b1};
                        pend_reg <= 1'b0;
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- src/client_table_rssi_tracker.sv -----
// Top level: station table tracker with APB register port.
// Observe: the input beat is queued, then the match loads the output register.
// Tick: a dispatch step, a sweep over every table entry and a closing step;
// the sweep and the closing step wait only while the output stalls.
// Observes sustain one item per cycle while the output is ready and no tick runs.
// Reset clears all valid bits, both counters and max_age to 10; no clearing pass.
module client_table_rssi_tracker
    import ctrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_ENTRIES
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [1:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    func,
    input  logic [MAC_W-1:0]        station_mac,
    input  logic signed [DBM_W-1:0] signal_dbm,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              event_kind,
    output logic [MAC_W-1:0]        client_mac,
    output logic signed [DBM_W-1:0] average_dbm,
    output logic signed [DBM_W-1:0] reference_dbm,
    output logic [CNT_W-1:0]        added_total,
    output logic [CNT_W-1:0]        removed_total,
    output logic                    final_event
);
    // Register index of max_age.
    localparam logic [1:0] ADDR_MAX_AGE = 2'd0;

    logic [15:0] max_age_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_AGE) ? {16'd0, max_age_reg} : 32'd0;

    // Write on the access beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_age_reg <= MAX_AGE_RESET;
        else if (psel && penable && pwrite && paddr == ADDR_MAX_AGE)
            max_age_reg <= pwdata[15:0];
    end

    cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;
    res_t res;
    assign in_cmd = '{func, station_mac, signal_dbm};

    ctrt_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    ctrt_back #(.ENTRIES(TABLE_ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n), .max_age(max_age_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
    );

    assign event_kind = res.kind;
    assign client_mac = res.mac;
    assign average_dbm = res.avg;
    assign reference_dbm = res.ref_dbm;
    assign added_total = res.added;
    assign removed_total = res.removed;
    assign final_event = res.fin;

    // Add events never carry a null or broadcast station.
    a_add_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == EV_ADD) |->
        (client_mac != '0 && client_mac != {MAC_W{1'b1}}))
        else $error("add event for null or broadcast MAC");

    // Observe events are always the final beat of their item.
    a_obs_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind != EV_REMOVE) |-> final_event)
        else $error("observe event not final");

    // A waiting result beat holds valid and its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(res)))
        else $error("result beat changed while waiting");
endmodule
